FILE: rtl/c437_pkg.sv
// ----------------------------------------------------------------------------
// c437_pkg
// Shared types, register indexes and code page 437 code point tables.
// ----------------------------------------------------------------------------
package c437_pkg;

    localparam logic [1:0] REG_DIRECTION = 2'd0;
    localparam logic [1:0] REG_LINE_STEP = 2'd1;
    localparam logic [1:0] REG_STRIP     = 2'd2;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_HOUSE   = 8'h7F;
    localparam logic [15:0] CP_HOUSE  = 16'h2302;

    // Work descriptor passed from front to back.
    typedef struct packed {
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [1:0]  nbytes;   // count minus one
        logic        number;   // emit line number prefix first
        logic [31:0] count;    // line number value
    } c437_work_t;

    function automatic logic [15:0] hi_cp(input logic [6:0] i);
        logic [15:0] r;
        begin
            case (i)
                7'd0: r = 16'h00C7; 7'd1: r = 16'h00FC; 7'd2: r = 16'h00E9; 7'd3: r = 16'h00E2;
                7'd4: r = 16'h00E4; 7'd5: r = 16'h00E0; 7'd6: r = 16'h00E5; 7'd7: r = 16'h00E7;
                7'd8: r = 16'h00EA; 7'd9: r = 16'h00EB; 7'd10: r = 16'h00E8; 7'd11: r = 16'h00EF;
                7'd12: r = 16'h00EE; 7'd13: r = 16'h00EC; 7'd14: r = 16'h00C4; 7'd15: r = 16'h00C5;
                7'd16: r = 16'h00C9; 7'd17: r = 16'h00E6; 7'd18: r = 16'h00C6; 7'd19: r = 16'h00F4;
                7'd20: r = 16'h00F6; 7'd21: r = 16'h00F2; 7'd22: r = 16'h00FB; 7'd23: r = 16'h00F9;
                7'd24: r = 16'h00FF; 7'd25: r = 16'h00D6; 7'd26: r = 16'h00DC; 7'd27: r = 16'h00A2;
                7'd28: r = 16'h00A3; 7'd29: r = 16'h00A5; 7'd30: r = 16'h20A7; 7'd31: r = 16'h0192;
                7'd32: r = 16'h00E1; 7'd33: r = 16'h00ED; 7'd34: r = 16'h00F3; 7'd35: r = 16'h00FA;
                7'd36: r = 16'h00F1; 7'd37: r = 16'h00D1; 7'd38: r = 16'h00AA; 7'd39: r = 16'h00BA;
                7'd40: r = 16'h00BF; 7'd41: r = 16'h2310; 7'd42: r = 16'h00AC; 7'd43: r = 16'h00BD;
                7'd44: r = 16'h00BC; 7'd45: r = 16'h00A1; 7'd46: r = 16'h00AB; 7'd47: r = 16'h00BB;
                7'd48: r = 16'h2591; 7'd49: r = 16'h2592; 7'd50: r = 16'h2593; 7'd51: r = 16'h2502;
                7'd52: r = 16'h2524; 7'd53: r = 16'h2561; 7'd54: r = 16'h2562; 7'd55: r = 16'h2556;
                7'd56: r = 16'h2555; 7'd57: r = 16'h2563; 7'd58: r = 16'h2551; 7'd59: r = 16'h2557;
                7'd60: r = 16'h255D; 7'd61: r = 16'h255C; 7'd62: r = 16'h255B; 7'd63: r = 16'h2510;
                7'd64: r = 16'h2514; 7'd65: r = 16'h2534; 7'd66: r = 16'h252C; 7'd67: r = 16'h251C;
                7'd68: r = 16'h2500; 7'd69: r = 16'h253C; 7'd70: r = 16'h255E; 7'd71: r = 16'h255F;
                7'd72: r = 16'h255A; 7'd73: r = 16'h2554; 7'd74: r = 16'h2569; 7'd75: r = 16'h2566;
                7'd76: r = 16'h2560; 7'd77: r = 16'h2550; 7'd78: r = 16'h256C; 7'd79: r = 16'h2567;
                7'd80: r = 16'h2568; 7'd81: r = 16'h2564; 7'd82: r = 16'h2565; 7'd83: r = 16'h2559;
                7'd84: r = 16'h2558; 7'd85: r = 16'h2552; 7'd86: r = 16'h2553; 7'd87: r = 16'h256B;
                7'd88: r = 16'h256A; 7'd89: r = 16'h2518; 7'd90: r = 16'h250C; 7'd91: r = 16'h2588;
                7'd92: r = 16'h2584; 7'd93: r = 16'h258C; 7'd94: r = 16'h2590; 7'd95: r = 16'h2580;
                7'd96: r = 16'h03B1; 7'd97: r = 16'h00DF; 7'd98: r = 16'h0393; 7'd99: r = 16'h03C0;
                7'd100: r = 16'h03A3; 7'd101: r = 16'h03C3; 7'd102: r = 16'h00B5; 7'd103: r = 16'h03C4;
                7'd104: r = 16'h03A6; 7'd105: r = 16'h0398; 7'd106: r = 16'h03A9; 7'd107: r = 16'h03B4;
                7'd108: r = 16'h221E; 7'd109: r = 16'h03C6; 7'd110: r = 16'h03B5; 7'd111: r = 16'h2229;
                7'd112: r = 16'h2261; 7'd113: r = 16'h00B1; 7'd114: r = 16'h2265; 7'd115: r = 16'h2264;
                7'd116: r = 16'h2320; 7'd117: r = 16'h2321; 7'd118: r = 16'h00F7; 7'd119: r = 16'h2248;
                7'd120: r = 16'h00B0; 7'd121: r = 16'h2219; 7'd122: r = 16'h00B7; 7'd123: r = 16'h221A;
                7'd124: r = 16'h207F; 7'd125: r = 16'h00B2; 7'd126: r = 16'h25A0;
                default: r = 16'h00A0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [15:0] byte_to_cp(input logic [7:0] b);
        logic [15:0] r;
        begin
            if (b < CH_HOUSE) r = {8'h00, b};
            else if (b == CH_HOUSE) r = CP_HOUSE;
            else r = hi_cp(b[6:0]);
            return r;
        end
    endfunction

    function automatic logic [7:0] alias_byte(input logic [20:0] cp);
        logic [7:0] r;
        begin
            case (cp)
                21'h03B2: r = 8'd225;
                21'h2211: r = 8'd228;
                21'h03BC: r = 8'd230;
                21'h2126: r = 8'd234;
                21'h00F0, 21'h2202: r = 8'd235;
                21'h2205, 21'h03D5, 21'h2300, 21'h00F8: r = 8'd237;
                21'h2208, 21'h20AC: r = 8'd238;
                default: r = CH_SPACE;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] cp_to_byte(input logic [20:0] cp, input logic ok);
        logic [7:0] r;
        logic       hit;
        begin
            r = CH_SPACE;
            hit = 1'b0;
            if (!ok) begin
                r = CH_SPACE;
            end else if (cp < 21'h7F) begin
                r = cp[7:0];
            end else if (cp == {5'd0, CP_HOUSE}) begin
                r = CH_HOUSE;
            end else begin
                for (int i = 0; i < 128; i++) begin
                    if (!hit && cp == {5'd0, hi_cp(7'(i))}) begin
                        r = 8'(128 + i);
                        hit = 1'b1;
                    end
                end
                if (!hit) r = alias_byte(cp);
            end
            return r;
        end
    endfunction

endpackage

FILE: rtl/c437_front.sv
// ----------------------------------------------------------------------------
// c437_front
// Accepts input bytes, gathers UTF-8 sequences, tracks line state and emits
// one work descriptor per byte that produces output.
// ----------------------------------------------------------------------------
module c437_front import c437_pkg::*; #(
    parameter int LINE_COUNTER_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       w_valid,
    input  logic       w_ready,
    output c437_work_t w_data
);

    localparam logic [LINE_COUNTER_BITS-1:0] CNT_MAX = '1;

    logic        dir_reg;
    logic [15:0] step_reg;
    logic        strip_reg;
    logic [7:0]  seq0_reg, seq1_reg, seq2_reg;
    logic [1:0]  cnt_reg;
    logic        start_reg;
    logic [LINE_COUNTER_BITS-1:0] line_reg;

    logic        accept;
    logic [7:0]  b0, b1, b2, b3;
    logic [2:0]  n;
    logic        ok;
    logic [20:0] cp;
    logic        emit;
    c437_work_t  work;
    logic        start_next;
    logic [LINE_COUNTER_BITS:0] sum;
    logic [15:0] cp437;

    assign s_ready = w_ready;
    assign accept  = s_valid && s_ready;
    assign cp437   = byte_to_cp(s_in_byte);
    assign sum     = {1'b0, line_reg} + (LINE_COUNTER_BITS+1)'(step_reg);

    always_comb begin
        logic [2:0] need;
        need = 3'd0;
        b0 = (cnt_reg == 2'd0) ? s_in_byte : seq0_reg;
        b1 = (cnt_reg == 2'd1) ? s_in_byte : seq1_reg;
        b2 = (cnt_reg == 2'd2) ? s_in_byte : seq2_reg;
        b3 = s_in_byte;
        n  = {1'b0, cnt_reg} + 3'd1;
        ok = 1'b0;
        cp = 21'd0;
        if (b0 < 8'h80) begin
            cp = {13'd0, b0};
            ok = (n == 3'd1);
        end else begin
            if (b0 inside {[8'hC2:8'hDF]}) need = 3'd2;
            else if (b0 inside {[8'hE0:8'hEF]}) need = 3'd3;
            else if (b0 inside {[8'hF0:8'hF4]}) need = 3'd4;
            if (need != 3'd0 && n == need) begin
                ok = 1'b1;
                if (b1[7:6] != 2'b10) ok = 1'b0;
                if (need > 3'd2 && b2[7:6] != 2'b10) ok = 1'b0;
                if (need > 3'd3 && b3[7:6] != 2'b10) ok = 1'b0;
                if (b0 == 8'hE0 && b1 < 8'hA0) ok = 1'b0;
                if (b0 == 8'hED && b1 > 8'h9F) ok = 1'b0;
                if (b0 == 8'hF0 && b1 < 8'h90) ok = 1'b0;
                if (b0 == 8'hF4 && b1 > 8'h8F) ok = 1'b0;
                case (need)
                    3'd2: cp = {10'd0, b0[4:0], b1[5:0]};
                    3'd3: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                    default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                endcase
            end
        end
    end

    always_comb begin
        work       = '0;
        work.count = 32'(line_reg);
        emit       = 1'b0;
        start_next = start_reg;
        if (dir_reg) begin
            if (ok || n == 3'd4) begin
                emit        = 1'b1;
                work.byte0  = cp_to_byte(cp, ok);
                work.nbytes = 2'd0;
                work.number = (step_reg != 16'd0) && start_reg;
                start_next  = ok && cp == 21'd10;
            end
        end else begin
            if (strip_reg && start_reg && cp437 >= 16'h30 && cp437 <= 16'h39) begin
                emit = 1'b0;
            end else if (strip_reg && start_reg && cp437 == 16'h20) begin
                start_next = 1'b0;
            end else begin
                emit       = 1'b1;
                start_next = (cp437 == 16'd10);
                if (cp437 < 16'h80) begin
                    work.byte0 = cp437[7:0];
                    work.nbytes = 2'd0;
                end else if (cp437 < 16'h800) begin
                    work.byte0 = {3'b110, cp437[10:6]};
                    work.byte1 = {2'b10, cp437[5:0]};
                    work.nbytes = 2'd1;
                end else begin
                    work.byte0 = {4'b1110, cp437[15:12]};
                    work.byte1 = {2'b10, cp437[11:6]};
                    work.byte2 = {2'b10, cp437[5:0]};
                    work.nbytes = 2'd2;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg   <= 1'b0;
            step_reg  <= 16'd0;
            strip_reg <= 1'b0;
            cnt_reg   <= 2'd0;
            start_reg <= 1'b1;
            line_reg  <= '0;
            w_valid   <= 1'b0;
        end else begin
            if (!cfg_we && accept && emit) w_valid <= 1'b1;
            else if (w_ready) w_valid <= 1'b0;
            if (cfg_we) begin
                case (cfg_index)
                    REG_DIRECTION: begin
                        dir_reg <= cfg_data[0];
                        cnt_reg <= 2'd0;
                    end
                    REG_LINE_STEP: begin
                        step_reg <= cfg_data;
                        if ({16'd0, cfg_data} > 32'(CNT_MAX)) line_reg <= CNT_MAX;
                        else line_reg <= LINE_COUNTER_BITS'(cfg_data);
                    end
                    REG_STRIP: strip_reg <= cfg_data[0];
                    default: ;
                endcase
            end else if (accept) begin
                start_reg <= start_next;
                if (dir_reg) begin
                    if (emit) cnt_reg <= 2'd0;
                    else begin
                        cnt_reg <= n[1:0];
                        case (cnt_reg)
                            2'd0: seq0_reg <= s_in_byte;
                            2'd1: seq1_reg <= s_in_byte;
                            default: seq2_reg <= s_in_byte;
                        endcase
                    end
                    if (work.number) begin
                        if (sum[LINE_COUNTER_BITS]) line_reg <= CNT_MAX;
                        else line_reg <= sum[LINE_COUNTER_BITS-1:0];
                    end
                end
                if (emit) w_data <= work;
            end
        end
    end

endmodule

FILE: rtl/c437_queue.sv
// ----------------------------------------------------------------------------
// c437_queue
// Small FIFO of work descriptors between front and back.
// ----------------------------------------------------------------------------
module c437_queue import c437_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  c437_work_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output c437_work_t out_data
);

    localparam int AW = $clog2(DEPTH);

    c437_work_t      mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     fill_reg;
    logic            push, pop;

    assign in_ready  = fill_reg != (AW+1)'(DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_data  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_reg] <= in_data;
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            fill_reg <= fill_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

FILE: rtl/c437_back.sv
// ----------------------------------------------------------------------------
// c437_back
// Expands a work descriptor into output beats: optional decimal line number
// (one digit per cycle while the output is free, through a double-dabble
// converter) and a space, then the character bytes.
// ----------------------------------------------------------------------------
module c437_back import c437_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       w_valid,
    output logic       w_ready,
    input  c437_work_t w_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CONV, ST_DIGIT, ST_SPACE, ST_CHAR
    } state_t;

    state_t      state_reg;
    c437_work_t  work_reg;
    logic [31:0] bin_reg;
    logic [39:0] bcd_reg;
    logic [5:0]  shift_reg;
    logic [3:0]  dig_reg;
    logic [1:0]  idx_reg;
    logic        out_free;
    logic [39:0] bcd_adj;
    logic [3:0]  top_dig;
    logic        beat_go;

    assign out_free = !m_valid || m_ready;
    assign w_ready  = (state_reg == ST_IDLE);
    assign beat_go  = out_free && (state_reg inside {ST_DIGIT, ST_SPACE, ST_CHAR});

    always_comb begin
        for (int i = 0; i < 10; i++) begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                bcd_reg[i*4 +: 4] + 4'd3 : bcd_reg[i*4 +: 4];
        end
    end

    always_comb begin
        top_dig = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (bcd_reg[i*4 +: 4] != 4'd0) top_dig = 4'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid   <= 1'b0;
        end else begin
            if (beat_go) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (w_valid) begin
                        work_reg <= w_data;
                        idx_reg  <= 2'd0;
                        if (w_data.number) begin
                            bin_reg   <= w_data.count;
                            bcd_reg   <= '0;
                            shift_reg <= 6'd32;
                            state_reg <= ST_CONV;
                        end else begin
                            state_reg <= ST_CHAR;
                        end
                    end
                end
                ST_CONV: begin
                    if (shift_reg == 6'd0) begin
                        dig_reg   <= top_dig;
                        state_reg <= ST_DIGIT;
                    end else begin
                        bcd_reg   <= {bcd_adj[38:0], bin_reg[31]};
                        bin_reg   <= {bin_reg[30:0], 1'b0};
                        shift_reg <= shift_reg - 6'd1;
                    end
                end
                ST_DIGIT: begin
                    if (out_free) begin
                        m_out_byte    <= CH_ZERO + {4'd0, bcd_reg[dig_reg*4 +: 4]};
                        m_last_of_run <= 1'b0;
                        if (dig_reg == 4'd0) state_reg <= ST_SPACE;
                        else dig_reg <= dig_reg - 4'd1;
                    end
                end
                ST_SPACE: begin
                    if (out_free) begin
                        m_out_byte    <= CH_SPACE;
                        m_last_of_run <= 1'b0;
                        state_reg     <= ST_CHAR;
                    end
                end
                ST_CHAR: begin
                    if (out_free) begin
                        m_last_of_run <= (idx_reg == work_reg.nbytes);
                        case (idx_reg)
                            2'd0: m_out_byte <= work_reg.byte0;
                            2'd1: m_out_byte <= work_reg.byte1;
                            default: m_out_byte <= work_reg.byte2;
                        endcase
                        if (idx_reg == work_reg.nbytes) state_reg <= ST_IDLE;
                        else idx_reg <= idx_reg + 2'd1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/cp437_utf8_transcoder_unit.sv
// ----------------------------------------------------------------------------
// cp437_utf8_transcoder_unit
// Code page 437 / UTF-8 byte-stream transcoder.
// ----------------------------------------------------------------------------
// Input bytes arrive on s_valid/s_ready/s_in_byte; output beats leave on
// m_valid/m_ready/m_out_byte with m_last_of_run on the final beat caused by
// one input byte. Registers (0 direction, 1 line step, 2 strip numbers) are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, which the block does not enforce. The front
// stage takes one byte per cycle while the queue has room and places a
// descriptor into a four-entry queue; the back stage sends at most one
// output beat per cycle. For a plain character the back stage takes its
// descriptor, then sends its bytes (one to three); a numbered line start
// adds binary-to-decimal conversion, the digits and the space. A plain
// character passes the front's descriptor register and the queue before
// its first beat. Reset clears the queue, restores all registers to zero
// and marks line start. When the receiver stalls, the back stage holds its
// beat, the queue fills, and s_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module cp437_utf8_transcoder_unit import c437_pkg::*; #(
    parameter int LINE_COUNTER_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_run
);

    logic       fw_valid, fw_ready, qb_valid, qb_ready;
    c437_work_t fw_data, qb_data;

    c437_front #(.LINE_COUNTER_BITS(LINE_COUNTER_BITS)) u_front (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_in_byte,
        .w_valid(fw_valid), .w_ready(fw_ready), .w_data(fw_data)
    );

    c437_queue #(.DEPTH(4)) u_queue (
        .aclk, .aresetn,
        .in_valid(fw_valid), .in_ready(fw_ready), .in_data(fw_data),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
    );

    c437_back u_back (
        .aclk, .aresetn,
        .w_valid(qb_valid), .w_ready(qb_ready), .w_data(qb_data),
        .m_valid, .m_ready, .m_out_byte, .m_last_of_run
    );

endmodule

FILE: rtl/c437_checker.sv
// ----------------------------------------------------------------------------
// c437_checker
// Port-level checks of the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module c437_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_last_of_run
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_of_run))
        else $error("output beat changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input beat dropped while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |-> s_ready)
        else $error("input not ready after reset");

endmodule

bind cp437_utf8_transcoder_unit c437_checker u_c437_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_out_byte, .m_last_of_run
);
